[rtl/vts_pkg.sv]
// shared types, codes and character classes for the verilog token splitter
// no dependencies; used by every module of the block

package vts_pkg;

   // default output queue depth (power of two, at least 4)
   localparam int OUT_DEPTH_DEFAULT = 8;

   // lexer state codes
   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_STR     = 3'd1;
   localparam logic [2:0] MODE_IDENT   = 3'd2;
   localparam logic [2:0] MODE_NUM     = 3'd3;
   localparam logic [2:0] MODE_COMMENT = 3'd4;
   localparam logic [2:0] MODE_HELD    = 3'd5;

   // token kind codes
   localparam logic [2:0] KIND_STR    = 3'd0;
   localparam logic [2:0] KIND_IDENT  = 3'd1;
   localparam logic [2:0] KIND_NUM    = 3'd2;
   localparam logic [2:0] KIND_OP2    = 3'd3;
   localparam logic [2:0] KIND_SINGLE = 3'd4;
   localparam logic [2:0] KIND_END    = 3'd5;

   // characters with a role of their own
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_TICK   = 8'h27;
   localparam logic [7:0] CH_BTICK  = 8'h60;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_NL     = 8'h0a;
   localparam logic [7:0] CH_SLASH  = 8'h2f;
   localparam logic [7:0] CH_UNDER  = 8'h5f;
   localparam logic [7:0] CH_EQ     = 8'h3d;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_LT     = 8'h3c;
   localparam logic [7:0] CH_GT     = 8'h3e;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_BAR    = 8'h7c;

   typedef struct packed {
      logic [7:0] ch;
      logic       is_end;
   } req_item_type;

   typedef struct packed {
      logic [7:0] tok_char;
      logic [2:0] kind;
      logic       first;
      logic       last_of_run;
   } rsp_item_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] held_char;
   } lex_state_type;

   // results of one item: how many, and the two slots in order
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } lex_out_type;

   function automatic logic is_space(input logic [7:0] c);
      return c inside {8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return c inside {[8'h41:8'h5a], [8'h61:8'h7a]};
   endfunction

   function automatic logic is_ident_start(input logic [7:0] c);
      return is_alpha(c) || c inside {CH_UNDER, CH_DOLLAR, CH_BTICK};
   endfunction

   function automatic logic is_ident_char(input logic [7:0] c);
      return is_ident_start(c) || is_digit(c);
   endfunction

   function automatic logic may_pair(input logic [7:0] c);
      return c inside {CH_EQ, CH_BANG, CH_LT, CH_GT, CH_AMP, CH_BAR};
   endfunction

   function automatic logic is_pair(input logic [7:0] a, input logic [7:0] b);
      return ((b == CH_EQ) && (a inside {CH_EQ, CH_BANG, CH_LT, CH_GT})) ||
             ((a == CH_LT) && (b == CH_LT)) || ((a == CH_GT) && (b == CH_GT)) ||
             ((a == CH_AMP) && (b == CH_AMP)) || ((a == CH_BAR) && (b == CH_BAR));
   endfunction

endpackage

[rtl/vts_chan_if.sv]
// valid/ready channel carrying one payload item per handshake
// payload type given by the instantiating level, usually from vts_pkg

interface vts_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/vts_lexer.sv]
// next-state and result logic of the tokenizer for one input item
// uses vts_pkg for codes, types and character classes

module vts_lexer
   import vts_pkg::*;
(
   input  req_item_type  item,
   input  lex_state_type state,
   output lex_state_type state_in,
   output lex_out_type   result
);

   logic         end_item;
   logic [7:0]   c;
   // what a byte does when it arrives between tokens
   logic         idle_emit;
   rsp_item_type idle_item;
   logic [2:0]   idle_mode;
   logic         idle_hold;
   rsp_item_type held_item;

   assign c        = item.ch;
   assign end_item = item.is_end || (c == CH_NUL);

   // byte arriving between tokens
   always_comb begin
      idle_emit = 1'b0;
      idle_hold = 1'b0;
      idle_mode = MODE_IDLE;
      idle_item = '{tok_char: c, kind: KIND_SINGLE, first: 1'b1, last_of_run: 1'b0};
      if (is_space(c)) begin
         idle_mode = MODE_IDLE;
      end else if (c == CH_DQUOTE) begin
         idle_emit      = 1'b1;
         idle_item.kind = KIND_STR;
         idle_mode      = MODE_STR;
      end else if (is_ident_start(c)) begin
         idle_emit      = 1'b1;
         idle_item.kind = KIND_IDENT;
         idle_mode      = MODE_IDENT;
      end else if (is_digit(c)) begin
         idle_emit      = 1'b1;
         idle_item.kind = KIND_NUM;
         idle_mode      = MODE_NUM;
      end else if ((c == CH_SLASH) || may_pair(c)) begin
         idle_hold = 1'b1;
         idle_mode = MODE_HELD;
      end else begin
         idle_emit = 1'b1;
      end
   end

   assign held_item = '{tok_char: state.held_char, kind: KIND_SINGLE, first: 1'b1,
                        last_of_run: 1'b0};

   // main decision on the current mode
   always_comb begin
      state_in     = state;
      result.count = 2'd0;
      result.item0 = idle_item;
      result.item1 = idle_item;
      if (end_item) begin
         result.item1 = '{tok_char: CH_NUL, kind: KIND_END, first: 1'b1, last_of_run: 1'b0};
         if (state.mode == MODE_HELD) begin
            result.item0 = held_item;
            result.count = 2'd2;
         end else begin
            result.item0 = result.item1;
            result.count = 2'd1;
         end
         state_in.mode      = MODE_IDLE;
         state_in.held_char = CH_NUL;
      end else begin
         case (state.mode)
            MODE_STR: begin
               result.item0 = '{tok_char: c, kind: KIND_STR, first: 1'b0, last_of_run: 1'b0};
               result.count = 2'd1;
               if (c == CH_DQUOTE) begin
                  state_in.mode = MODE_IDLE;
               end
            end
            MODE_IDENT, MODE_NUM: begin
               if (((state.mode == MODE_IDENT) && is_ident_char(c)) ||
                   ((state.mode == MODE_NUM) &&
                    (is_alpha(c) || is_digit(c) || (c == CH_TICK)))) begin
                  result.item0 = '{tok_char: c,
                                   kind: (state.mode == MODE_IDENT) ? KIND_IDENT : KIND_NUM,
                                   first: 1'b0, last_of_run: 1'b0};
                  result.count = 2'd1;
               end else begin
                  result.count  = {1'b0, idle_emit};
                  state_in.mode = idle_mode;
                  if (idle_hold) begin
                     state_in.held_char = c;
                  end
               end
            end
            MODE_COMMENT: begin
               if (c == CH_NL) begin
                  state_in.mode = MODE_IDLE;
               end
            end
            MODE_HELD: begin
               if ((state.held_char == CH_SLASH) && (c == CH_SLASH)) begin
                  state_in.mode = MODE_COMMENT;
               end else if (is_pair(state.held_char, c)) begin
                  result.item0 = '{tok_char: state.held_char, kind: KIND_OP2, first: 1'b1,
                                   last_of_run: 1'b0};
                  result.item1 = '{tok_char: c, kind: KIND_OP2, first: 1'b0,
                                   last_of_run: 1'b0};
                  result.count  = 2'd2;
                  state_in.mode = MODE_IDLE;
               end else begin
                  // flush the held byte, then take the new one as between tokens
                  result.item0  = held_item;
                  result.count  = idle_emit ? 2'd2 : 2'd1;
                  state_in.mode = idle_mode;
                  if (idle_hold) begin
                     state_in.held_char = c;
                  end
               end
            end
            default: begin
               result.count  = {1'b0, idle_emit};
               state_in.mode = idle_mode;
               if (idle_hold) begin
                  state_in.held_char = c;
               end
            end
         endcase
      end
      // mark the last result of this item
      result.item0.last_of_run = (result.count == 2'd1);
      result.item1.last_of_run = 1'b1;
   end

endmodule

[rtl/vts_out_fifo.sv]
// output queue of result items: up to two written per cycle, one read per cycle while the receiver is ready
// uses vts_pkg for the result type and vts_chan_if for the output channel

module vts_out_fifo
   import vts_pkg::*;
#(
   parameter int DEPTH = OUT_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [1:0]                 push_count,
   input  rsp_item_type               push_item0,
   input  rsp_item_type               push_item1,
   output logic [$clog2(DEPTH+1)-1:0] fill,
   vts_chan_if.source                 rsp_chan
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   rsp_item_type    slot_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff;
   logic [AW-1:0]   wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff;
   logic [AW-1:0]   rd_ptr_in;
   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   count_in;
   logic            pop;

   assign pop              = rsp_chan.valid && rsp_chan.ready;
   assign rsp_chan.valid   = (count_ff != '0);
   assign rsp_chan.payload = slot_ff[rd_ptr_ff];
   assign fill             = count_ff;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff + AW'(push_count);
      rd_ptr_in = rd_ptr_ff + AW'(pop);
      count_in  = count_ff + CW'(push_count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // result slots, written in item order
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push_item0;
      end
      if (push_count == 2'd2) begin
         slot_ff[wr_ptr_ff + AW'(1)] <= push_item1;
      end
   end

   // queue never written past its depth
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      ((CW+1)'(count_ff) + (CW+1)'(push_count) <= (CW+1)'(DEPTH)))
      else $error("output queue overflow");

   // fill follows pushes and pops
   a_fill_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff) + CW'($past(push_count))
                         - CW'($past(pop))))
      else $error("output queue fill count out of step");

   // fill never exceeds the depth
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CW'(DEPTH)))
      else $error("output queue fill beyond depth");

   // a pair of writes never reports more than two items
   a_push_range: assert property (@(posedge clock) disable iff (reset)
      (push_count != 2'd3))
      else $error("invalid push count");

endmodule

[rtl/verilog_token_splitter_unit.sv]
// Streaming Verilog tokenizer: one source byte per input item, one token character per
// result item with its kind and a first-of-token mark; whitespace and line comments are
// dropped, operator and slash bytes wait one item for lookahead. An input item is taken in
// any cycle while the output queue has room for the items already in flight, and it
// gives its results (zero to two) first through the input register, then through the
// lexer logic into the output queue. The output side delivers one result per cycle while
// the receiver is ready, so the sustained rate is set by the output port: one item per
// cycle when each item gives at most one result, slower for items that give two. OUT_DEPTH
// must be a power of two, at least 4.
// uses vts_pkg, vts_chan_if, vts_lexer and vts_out_fifo

module verilog_token_splitter_unit
   import vts_pkg::*;
#(
   parameter int OUT_DEPTH = OUT_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   vts_chan_if.sink   req_chan,
   vts_chan_if.source rsp_chan
);

   localparam int CW = $clog2(OUT_DEPTH + 1);

   logic                stage_valid_ff;
   req_item_type        stage_item_ff;
   lex_state_type       state_ff;
   lex_state_type       state_in;
   lex_out_type         lex_out;
   logic [1:0]          push_count;
   logic [CW-1:0]       fill;
   logic                accept;

   // room for the staged item's results plus two more from a new item
   assign push_count     = stage_valid_ff ? lex_out.count : 2'd0;
   assign req_chan.ready = ((CW+1)'(fill) + (CW+1)'(push_count)) <= (CW+1)'(OUT_DEPTH - 2);
   assign accept         = req_chan.valid && req_chan.ready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_item_ff <= req_chan.payload;
      end
   end

   // tokenizer state, advanced once per staged item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode      <= MODE_IDLE;
         state_ff.held_char <= CH_NUL;
      end else if (stage_valid_ff) begin
         state_ff <= state_in;
      end
   end

   vts_lexer u_lexer (
      .item     (stage_item_ff),
      .state    (state_ff),
      .state_in (state_in),
      .result   (lex_out)
   );

   vts_out_fifo #(
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_item0 (lex_out.item0),
      .push_item1 (lex_out.item1),
      .fill       (fill),
      .rsp_chan   (rsp_chan)
   );

endmodule

[tb/vts_token_checker.sv]
`timescale 1ns / 1ps
// token checker for verilog_token_splitter_unit: predicts token characters from accepted
// source items and compares them with accepted results; depends on vts_pkg

module vts_token_checker
   import vts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_item_type req_item,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_item_type rsp_item,
   output int           fail_count,
   output int           tokens_pending
);

   // predicted token characters, oldest first
   rsp_item_type expected_tokens[$];

   // lexer state of the predictor
   logic [2:0] tok_mode = MODE_IDLE;
   logic [7:0] held_byte = CH_NUL;

   // results of the item being predicted
   rsp_item_type step_out[2];
   int step_count = 0;
   int fail_total = 0;

   // character classes
   function automatic logic char_is_blank(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
   endfunction

   function automatic logic char_is_num(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic char_is_letter(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic logic char_opens_word(input logic [7:0] c);
      return char_is_letter(c) || c == CH_UNDER || c == CH_DOLLAR || c == CH_BTICK;
   endfunction

   function automatic logic char_opens_pair(input logic [7:0] c);
      return c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT ||
             c == CH_AMP || c == CH_BAR;
   endfunction

   function automatic logic chars_form_pair(input logic [7:0] a, input logic [7:0] b);
      if (b == CH_EQ && (a == CH_EQ || a == CH_BANG || a == CH_LT || a == CH_GT))
         return 1'b1;
      return (a == b) && (a == CH_LT || a == CH_GT || a == CH_AMP || a == CH_BAR);
   endfunction

   function automatic void put_token(input logic [7:0] c, input logic [2:0] k,
                                     input logic f);
      step_out[step_count] = '{tok_char: c, kind: k, first: f, last_of_run: 1'b0};
      step_count++;
   endfunction

   // a byte seen between tokens
   function automatic void open_token(input logic [7:0] c);
      tok_mode = MODE_IDLE;
      if (c == CH_DQUOTE) begin
         put_token(c, KIND_STR, 1'b1);
         tok_mode = MODE_STR;
      end else if (char_opens_word(c)) begin
         put_token(c, KIND_IDENT, 1'b1);
         tok_mode = MODE_IDENT;
      end else if (char_is_num(c)) begin
         put_token(c, KIND_NUM, 1'b1);
         tok_mode = MODE_NUM;
      end else if (c == CH_SLASH || char_opens_pair(c)) begin
         held_byte = c;
         tok_mode = MODE_HELD;
      end else if (!char_is_blank(c)) begin
         put_token(c, KIND_SINGLE, 1'b1);
      end
   endfunction

   // advance the predictor by one source item and queue its results
   function automatic void predict_item(input req_item_type it);
      logic [7:0] c;
      int i;
      c = it.ch;
      step_count = 0;
      if (it.is_end || c == CH_NUL) begin
         if (tok_mode == MODE_HELD)
            put_token(held_byte, KIND_SINGLE, 1'b1);
         put_token(CH_NUL, KIND_END, 1'b1);
         tok_mode = MODE_IDLE;
         held_byte = CH_NUL;
      end else begin
         case (tok_mode)
            MODE_STR: begin
               put_token(c, KIND_STR, 1'b0);
               if (c == CH_DQUOTE)
                  tok_mode = MODE_IDLE;
            end
            MODE_IDENT: begin
               if (char_opens_word(c) || char_is_num(c))
                  put_token(c, KIND_IDENT, 1'b0);
               else
                  open_token(c);
            end
            MODE_NUM: begin
               if (char_is_letter(c) || char_is_num(c) || c == CH_TICK)
                  put_token(c, KIND_NUM, 1'b0);
               else
                  open_token(c);
            end
            MODE_COMMENT: begin
               if (c == CH_NL)
                  tok_mode = MODE_IDLE;
            end
            MODE_HELD: begin
               if (held_byte == CH_SLASH && c == CH_SLASH) begin
                  tok_mode = MODE_COMMENT;
               end else if (chars_form_pair(held_byte, c)) begin
                  put_token(held_byte, KIND_OP2, 1'b1);
                  put_token(c, KIND_OP2, 1'b0);
                  tok_mode = MODE_IDLE;
               end else begin
                  put_token(held_byte, KIND_SINGLE, 1'b1);
                  open_token(c);
               end
            end
            default: open_token(c);
         endcase
      end
      for (i = 0; i < step_count; i++) begin
         if (i == step_count - 1)
            step_out[i].last_of_run = 1'b1;
         expected_tokens.push_back(step_out[i]);
      end
   endfunction

   // watch both channels at every rising edge
   always @(posedge clock) begin : watch
      rsp_item_type want;
      if (reset) begin
         tok_mode = MODE_IDLE;
         held_byte = CH_NUL;
         expected_tokens.delete();
      end else begin
         if (req_valid && req_ready)
            predict_item(req_item);
         if (rsp_valid && rsp_ready) begin
            if (expected_tokens.size() == 0) begin
               $error("result with nothing expected: tok_char %h kind %0d",
                      rsp_item.tok_char, rsp_item.kind);
               fail_total++;
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_item.tok_char !== want.tok_char) begin
                  $error("tok_char: expected %h, got %h", want.tok_char, rsp_item.tok_char);
                  fail_total++;
               end
               if (rsp_item.kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp_item.kind);
                  fail_total++;
               end
               if (rsp_item.first !== want.first) begin
                  $error("first: expected %b, got %b", want.first, rsp_item.first);
                  fail_total++;
               end
               if (rsp_item.last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %b, got %b",
                         want.last_of_run, rsp_item.last_of_run);
                  fail_total++;
               end
            end
         end
      end
      fail_count <= fail_total;
      tokens_pending <= expected_tokens.size();
   end

endmodule

[tb/verilog_token_splitter_unit_test.sv]
`timescale 1ns / 1ps
// top of the token splitter testbench: clock, reset, source text and receiver stalls
// depends on vts_pkg, vts_chan_if, verilog_token_splitter_unit and vts_token_checker

module verilog_token_splitter_unit_test;
   import vts_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SOURCE_ITEMS = 1100;
   localparam int DRAIN_CYCLES = 20;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_COIN,
      STALL_SPARSE,
      STALL_TOGGLE
   } stall_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic src_valid = 1'b0;
   req_item_type src_item = '0;
   logic sink_ready = 1'b0;

   int burst_left = 0;
   int items_sent = 0;
   int random_base = 0;
   int cycles = 0;
   int fail_count;
   int tokens_pending;
   stall_style_type stall_style = STALL_NONE;
   int stall_left = 0;

   logic [7:0] pair_lead [0:5] = '{CH_EQ, CH_BANG, CH_LT, CH_GT, CH_AMP, CH_BAR};
   logic [7:0] blank_set [0:5] = '{8'h20, 8'h09, CH_NL, 8'h0b, 8'h0c, 8'h0d};
   logic [7:0] word_mark [0:2] = '{CH_UNDER, CH_DOLLAR, CH_BTICK};

   vts_chan_if #(.payload_type(req_item_type)) req_chan ();
   vts_chan_if #(.payload_type(rsp_item_type)) rsp_chan ();

   assign req_chan.valid = src_valid;
   assign req_chan.payload = src_item;
   assign rsp_chan.ready = sink_ready;

   verilog_token_splitter_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   vts_token_checker token_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_item       (req_chan.payload),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_item       (rsp_chan.payload),
      .fail_count     (fail_count),
      .tokens_pending (tokens_pending)
   );

   // clock, 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver stalls, in a style picked at random for each run of stalls
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_style = stall_style_type'($urandom_range(0, 3));
         stall_left = $urandom_range(5, 60);
      end
      stall_left--;
      case (stall_style)
         STALL_NONE:   sink_ready = 1'b1;
         STALL_COIN:   sink_ready = 1'($urandom_range(0, 1));
         STALL_SPARSE: sink_ready = ($urandom_range(0, 3) == 0);
         default:      sink_ready = ~sink_ready;
      endcase
   end

   // one source item, sent in bursts with random gaps
   task automatic send_item(input logic [7:0] c, input logic e);
      @(negedge clock);
      if (burst_left == 0) begin
         src_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      src_item = '{ch: c, is_end: e};
      src_valid = 1'b1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      burst_left--;
      items_sent++;
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++)
         send_item(s[i], 1'b0);
   endtask

   function automatic logic [7:0] word_char(input logic lead);
      case ($urandom_range(0, lead ? 2 : 3))
         0:       return 8'($urandom_range("A", "Z"));
         1:       return 8'($urandom_range("a", "z"));
         2:       return word_mark[$urandom_range(0, 2)];
         default: return 8'($urandom_range("0", "9"));
      endcase
   endfunction

   // one random token, mostly well formed, sometimes noise or end of source
   task automatic send_random_token();
      int pick;
      int len;
      int i;
      logic [7:0] c;
      pick = $urandom_range(0, 99);
      if (pick < 18) begin
         // identifier, system task or macro name
         send_item(word_char(1'b1), 1'b0);
         len = $urandom_range(0, 7);
         for (i = 0; i < len; i++)
            send_item(word_char(1'b0), 1'b0);
      end else if (pick < 32) begin
         // number, possibly sized with a base
         send_item(8'($urandom_range("0", "9")), 1'b0);
         len = $urandom_range(0, 6);
         for (i = 0; i < len; i++) begin
            case ($urandom_range(0, 3))
               0:       c = 8'($urandom_range("0", "9"));
               1:       c = 8'($urandom_range("a", "z"));
               2:       c = CH_TICK;
               default: c = 8'($urandom_range("A", "Z"));
            endcase
            send_item(c, 1'b0);
         end
      end else if (pick < 44) begin
         // string literal with arbitrary bytes, sometimes unterminated
         send_item(CH_DQUOTE, 1'b0);
         len = $urandom_range(0, 8);
         for (i = 0; i < len; i++) begin
            c = 8'($urandom_range(1, 255));
            if (c == CH_DQUOTE)
               c = 8'h20;
            send_item(c, 1'b0);
         end
         if ($urandom_range(0, 9) != 0)
            send_item(CH_DQUOTE, 1'b0);
      end else if (pick < 60) begin
         // operator lead and a second byte that may complete it
         send_item(pair_lead[$urandom_range(0, 5)], 1'b0);
         send_item(($urandom_range(0, 1) == 0) ? CH_EQ : pair_lead[$urandom_range(0, 5)],
                   1'b0);
      end else if (pick < 70) begin
         // slash, often opening a line comment
         send_item(CH_SLASH, 1'b0);
         if ($urandom_range(0, 2) != 0) begin
            send_item(CH_SLASH, 1'b0);
            len = $urandom_range(0, 10);
            for (i = 0; i < len; i++) begin
               c = 8'($urandom_range(1, 255));
               if (c == CH_NL)
                  c = CH_SLASH;
               send_item(c, 1'b0);
            end
            if ($urandom_range(0, 4) != 0)
               send_item(CH_NL, 1'b0);
         end
      end else if (pick < 84) begin
         // whitespace
         len = $urandom_range(1, 3);
         for (i = 0; i < len; i++)
            send_item(blank_set[$urandom_range(0, 5)], 1'b0);
      end else if (pick < 97) begin
         // any byte but zero
         send_item(8'($urandom_range(1, 255)), 1'b0);
      end else if (pick < 99) begin
         // end item, byte ignored
         send_item(8'($urandom_range(0, 255)), 1'b1);
      end else begin
         // zero byte as end of source
         send_item(CH_NUL, 1'b0);
      end
   endtask

   // time limit
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("verilog_token_splitter_unit: mismatch");
      $finish;
   end

   // stimulus and verdict
   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // identifier with backtick, letter, digit and dollar, pair, held bang, number, held slash
      send_item(CH_BTICK, 1'b0);
      send_text("a9$==!x 8'hF/x");
      // comment holding a quote, ended by newline
      send_text("//\"c\n");
      send_item(8'h0b, 1'b0);
      send_item(8'h0c, 1'b0);
      send_item(8'h0d, 1'b0);
      // string with space and slash inside
      send_text("\" /\"");
      // high bytes are single characters
      send_item(8'hff, 1'b0);
      send_item(8'h80, 1'b0);
      // held operator flushed by an end item, then a zero byte as a repeated end
      send_item(CH_LT, 1'b0);
      send_item(8'hff, 1'b1);
      send_item(CH_NUL, 1'b0);
      // unterminated string cut off by end of source
      send_item(CH_DQUOTE, 1'b0);
      send_item(CH_NUL, 1'b1);

      random_base = items_sent;
      while (items_sent - random_base < SOURCE_ITEMS)
         send_random_token();

      @(negedge clock);
      src_valid = 1'b0;
      while (tokens_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && tokens_pending == 0)
         $display("verilog_token_splitter_unit: match");
      else
         $display("verilog_token_splitter_unit: mismatch");
      $finish;
   end

endmodule
